// ----- src/word_parallel_byte_search_assert.svh -----
// ---------------------------------------------------------------------------
// Word-parallel byte search assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef WORD_PARALLEL_BYTE_SEARCH_ASSERT_SVH
`define WORD_PARALLEL_BYTE_SEARCH_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WPBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define WPBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/wpbs_pkg.sv -----
// ---------------------------------------------------------------------------
// Word-parallel byte search package
// Beat types, configuration types, register indexes and status codes.
// ---------------------------------------------------------------------------
package wpbs_pkg;

    localparam int DATA_W          = 64;
    localparam int DATA_LANES      = DATA_W / 8;
    localparam int OFFSET_W        = 32;
    localparam int RANGE_W         = 32;
    localparam int START_W         = 3;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int DEF_LENGTH_BITS = 32;
    localparam int DEF_WORD_BYTES  = 8;

    // Status codes of a result beat.
    localparam logic [1:0] ST_SEARCHING = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_BYTE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_OFFSET = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LENGTH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BIG_ENDIAN   = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] data_word;
        logic              first_word;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [OFFSET_W-1:0] match_offset;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]         search_byte;
        logic [START_W-1:0] start_offset;
        logic [RANGE_W-1:0] range_length;
        logic               big_endian_lanes;
    } cfg_t;

endpackage

// ----- src/wpbs_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// Word-parallel byte search configuration registers
// Holds the four search settings written through the configuration port.
// ---------------------------------------------------------------------------
module wpbs_cfg_regs
    import wpbs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_SEARCH_BYTE:  cfg_next.search_byte      = wr_data[7:0];
                REG_START_OFFSET: cfg_next.start_offset     = wr_data[START_W-1:0];
                REG_RANGE_LENGTH: cfg_next.range_length     = wr_data[RANGE_W-1:0];
                REG_BIG_ENDIAN:   cfg_next.big_endian_lanes = wr_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/wpbs_lane_match.sv -----
// ---------------------------------------------------------------------------
// Word-parallel byte search lane matcher
// Compares every byte lane of a word, masks lanes outside the range and
// picks the lowest-addressed match.
// ---------------------------------------------------------------------------
module wpbs_lane_match
    import wpbs_pkg::*;
#(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS,
    parameter int WORD_BYTES  = DEF_WORD_BYTES
)
(
    input  logic [DATA_W-1:0]                  data_word,
    input  logic [7:0]                         search_byte,
    input  logic                               big_endian_lanes,
    input  logic [$clog2(WORD_BYTES)-1:0]      lo,
    input  logic [LENGTH_BITS-1:0]             bytes_left,
    output logic                               hit,
    output logic [$clog2(WORD_BYTES)-1:0]      hit_j
);

    localparam int LANE_W = $clog2(WORD_BYTES);
    localparam int TAKE_W = $clog2(WORD_BYTES + 1);

    logic [7:0]            byte_le [WORD_BYTES];
    logic [7:0]            byte_be [WORD_BYTES];
    logic [WORD_BYTES-1:0] match;
    logic [LANE_W-1:0]     hit_addr;

    // Address a sits in lane a or lane WORD_BYTES-1-a; lanes past the data
    // word read as zero.
    for (genvar a = 0; a < WORD_BYTES; a++)
    begin : g_lane
        localparam int LE = a;
        localparam int BE = WORD_BYTES - 1 - a;
        if (LE < DATA_LANES)
        begin : g_le
            assign byte_le[a] = data_word[8*LE +: 8];
        end
        else
        begin : g_le_zero
            assign byte_le[a] = 8'd0;
        end
        if (BE < DATA_LANES)
        begin : g_be
            assign byte_be[a] = data_word[8*BE +: 8];
        end
        else
        begin : g_be_zero
            assign byte_be[a] = 8'd0;
        end
    end

    always_comb
    begin
        logic [TAKE_W-1:0] diff;
        logic [7:0]        lane_byte;
        for (int a = 0; a < WORD_BYTES; a++)
        begin
            diff      = TAKE_W'(a) - TAKE_W'(lo);
            lane_byte = big_endian_lanes ? byte_be[a] : byte_le[a];
            match[a]  = (TAKE_W'(a) >= TAKE_W'(lo))
                     && (LENGTH_BITS'(diff) < bytes_left)
                     && (lane_byte == search_byte);
        end
    end

    always_comb
    begin
        hit      = 1'b0;
        hit_addr = '0;
        for (int a = WORD_BYTES - 1; a >= 0; a--)
        begin
            if (match[a])
            begin
                hit      = 1'b1;
                hit_addr = LANE_W'(a);
            end
        end
    end

    assign hit_j = hit_addr - lo;

endmodule

// ----- src/wpbs_seq.sv -----
// ---------------------------------------------------------------------------
// Word-parallel byte search sequencing
// Keeps the running search state and forms the result of each word.
// ---------------------------------------------------------------------------
module wpbs_seq
    import wpbs_pkg::*;
#(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS,
    parameter int WORD_BYTES  = DEF_WORD_BYTES
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_beat_t  beat,
    input  cfg_t      cfg,
    output out_beat_t result,
    output logic      search_active
);

    localparam int LANE_W    = $clog2(WORD_BYTES);
    localparam int TAKE_W    = $clog2(WORD_BYTES + 1);
    localparam int POS_W     = LENGTH_BITS + 1;
    localparam int OFS_EXT_W = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;
    localparam int RL_EXT_W  = (LENGTH_BITS > RANGE_W) ? LENGTH_BITS : RANGE_W;
    localparam int SO_W      = (TAKE_W > START_W) ? TAKE_W : START_W;

    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [POS_W-1:0]       word_position_reg, word_position_next;
    logic                   search_active_reg, search_active_next;

    logic [SO_W-1:0]        so_ext;
    logic [LANE_W-1:0]      lo_first, lo;
    logic [RL_EXT_W-1:0]    rl_ext;
    logic [LENGTH_BITS-1:0] bl, bl_after;
    logic [POS_W-1:0]       base, pos_hit;
    logic [OFS_EXT_W-1:0]   ofs_ext;
    logic [TAKE_W-1:0]      avail, take;
    logic                   active, hit;
    logic [LANE_W-1:0]      hit_j;

    // The start offset is below twice the word size, so one subtract
    // reduces it modulo the word size.
    assign so_ext   = SO_W'(cfg.start_offset);
    assign lo_first = LANE_W'((so_ext >= SO_W'(WORD_BYTES)) ? so_ext - SO_W'(WORD_BYTES)
                                                            : so_ext);
    assign rl_ext   = RL_EXT_W'(cfg.range_length);

    assign active = beat.first_word || search_active_reg;
    assign lo     = beat.first_word ? lo_first : '0;
    assign bl     = beat.first_word ? rl_ext[LENGTH_BITS-1:0] : bytes_left_reg;
    assign base   = beat.first_word ? '0 : word_position_reg;

    assign avail    = TAKE_W'(WORD_BYTES) - TAKE_W'(lo);
    assign take     = (bl < LENGTH_BITS'(avail)) ? TAKE_W'(bl) : avail;
    assign bl_after = bl - LENGTH_BITS'(take);

    wpbs_lane_match #(
        .LENGTH_BITS (LENGTH_BITS),
        .WORD_BYTES  (WORD_BYTES)
    ) u_lane_match (
        .data_word        (beat.data_word),
        .search_byte      (cfg.search_byte),
        .big_endian_lanes (cfg.big_endian_lanes),
        .lo               (lo),
        .bytes_left       (bl),
        .hit              (hit),
        .hit_j            (hit_j)
    );

    assign pos_hit = base + POS_W'(hit_j);
    assign ofs_ext = OFS_EXT_W'(pos_hit);

    always_comb
    begin
        result.status       = ST_SEARCHING;
        result.match_offset = '0;
        search_active_next  = search_active_reg;
        bytes_left_next     = bytes_left_reg;
        word_position_next  = word_position_reg;
        if (!active)
        begin
            result.status = ST_IGNORED;
        end
        else if (hit)
        begin
            result.status       = ST_FOUND;
            result.match_offset = ofs_ext[OFFSET_W-1:0];
            search_active_next  = 1'b0;
            bytes_left_next     = bl;
        end
        else if (bl_after == '0)
        begin
            result.status      = ST_NOT_FOUND;
            search_active_next = 1'b0;
            bytes_left_next    = '0;
        end
        else
        begin
            search_active_next = 1'b1;
            bytes_left_next    = bl_after;
            word_position_next = base + POS_W'(take);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg    <= '0;
            word_position_reg <= '0;
            search_active_reg <= 1'b0;
        end
        else if (fire)
        begin
            bytes_left_reg    <= bytes_left_next;
            word_position_reg <= word_position_next;
            search_active_reg <= search_active_next;
        end
    end

    assign search_active = search_active_reg;

endmodule

// ----- src/word_parallel_byte_search.sv -----
// ---------------------------------------------------------------------------
// Word-parallel byte search
// Finds the first byte equal to a set value in a byte range that streams in
// as aligned words, one result beat per word.
// ---------------------------------------------------------------------------
// The block takes one aligned memory word per beat and returns one result
// beat per word, in order: searching, found (with the byte offset of the
// match from the range start), not found (at the word holding the last byte
// of the range), or ignored once the search has ended. A word flagged as
// first word starts a new search at the configured start offset. It accepts
// one word every clock cycle while the result register is not held up, and
// each result is presented from the result register: the word waits in the
// input register while the lane compare, range mask, priority encoder and
// state update run, and the result register takes the outcome when the
// word moves on. That state loop, which carries the bytes left and the
// running position from one word to the next, sets the rate. The
// configuration port is always ready; settings should be changed only while
// no word is in flight. The input register stays free to take a new beat
// whenever the result register is emptying or empty.
// ---------------------------------------------------------------------------
module word_parallel_byte_search
    import wpbs_pkg::*;
#(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS,
    parameter int WORD_BYTES  = DEF_WORD_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_beat_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_beat_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "word_parallel_byte_search_assert.svh"

    cfg_t      cfg;
    logic      s1_valid_reg, s1_valid_next;
    in_beat_t  s1_beat_reg;
    logic      out_valid_reg, out_valid_next;
    out_beat_t out_beat_reg;
    out_beat_t result;
    logic      s1_fire;
    logic      search_active;

    // Settings registers; writes are taken in every cycle.
    assign cfg_ready = 1'b1;

    wpbs_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The word in the input register moves on when the result register is
    // empty or hands its beat over in the same cycle.
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    assign s1_valid_next  = (in_valid && in_ready) || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_beat_reg <= in_data;
        end
        if (s1_fire)
        begin
            out_beat_reg <= result;
        end
    end

    wpbs_seq #(
        .LENGTH_BITS (LENGTH_BITS),
        .WORD_BYTES  (WORD_BYTES)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (s1_fire),
        .beat          (s1_beat_reg),
        .cfg           (cfg),
        .result        (result),
        .search_active (search_active)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

    // A word leaving the input register always lands in the result register.
    `WPBS_ASSERT_NEXT(a_fire_lands, s1_fire, out_valid, "word lost between stages")

    // Only a found result carries an offset.
    `WPBS_ASSERT_NOW(a_offset_only_found, out_valid && (out_data.status != ST_FOUND),
                     out_data.match_offset == '0, "offset on a result that is not found")

    // A search that finishes leaves no search running.
    `WPBS_ASSERT_NEXT(a_end_clears, s1_fire && ((result.status == ST_FOUND)
                      || (result.status == ST_NOT_FOUND)), !search_active,
                      "search still active after it ended")

endmodule

// ----- bench/tb_word_parallel_byte_search.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Word-parallel byte search testbench
// Streams aligned memory words through the search block under a series of
// register settings. Every accepted word is run through a software copy of
// the search, and each result beat is compared with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_word_parallel_byte_search;
    import wpbs_pkg::*;

    // Rough number of words to send; the stimulus stops once this is reached.
    localparam int WORD_TARGET   = 1950;
    // Words at the tail of the run that are sent with no idling on either side.
    localparam int QUIET_TAIL    = 250;
    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT   = 4000;
    // Longest stretch of words taken for one search in the random part.
    localparam int MAX_SEQ_WORDS = 10;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_beat_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Words waiting to be sent, and the verdicts predicted for accepted words.
    in_beat_t  words_to_send[$];
    out_beat_t predicted_verdicts[$];

    // Mirror of the block's registers and of its search state.
    cfg_t        active_cfg;
    logic [31:0] bytes_left;
    logic [32:0] next_position;
    logic        search_on;

    // Idling controls: a burst starts with a chance of one in the given odds,
    // and odds of zero mean no idling at all.
    int unsigned send_idle_odds = 0;
    int unsigned recv_idle_odds = 0;
    int unsigned send_gap_left  = 0;
    int unsigned recv_stall_left = 0;

    int unsigned fail_count    = 0;
    int unsigned queued_words  = 0;
    int unsigned sent_words    = 0;
    int unsigned setting_count = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned seen_searching = 0;
    int unsigned seen_found     = 0;
    int unsigned seen_not_found = 0;
    int unsigned seen_ignored   = 0;
    out_beat_t   oldest_verdict;

    word_parallel_byte_search i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    // Runs one accepted word through the search and returns its verdict. The
    // first word of a range starts at the configured lane; later words start
    // at address zero and carry on from the running position. Only the lanes
    // still inside the range are looked at, in address order, so the lowest
    // matching address wins.
    function automatic out_beat_t search_word(in_beat_t beat);
        out_beat_t   verdict;
        logic [2:0]  lo;
        logic [32:0] base;
        logic [31:0] avail;
        logic [31:0] take;
        logic [32:0] hit_position;
        int          lane;
        verdict = '0;
        verdict.status = ST_SEARCHING;
        if (beat.first_word)
        begin
            search_on  = 1'b1;
            bytes_left = active_cfg.range_length;
            lo         = active_cfg.start_offset;
            base       = '0;
        end
        else if (!search_on)
        begin
            // No search in progress: the word is passed over and nothing moves.
            verdict.status = ST_IGNORED;
            return verdict;
        end
        else
        begin
            lo   = '0;
            base = next_position;
        end
        avail = 32'd8 - 32'(lo);
        take  = (bytes_left < avail) ? bytes_left : avail;
        for (int j = 0; j < int'(take); j++)
        begin
            lane = active_cfg.big_endian_lanes ? 7 - (int'(lo) + j) : int'(lo) + j;
            if (beat.data_word[lane*8 +: 8] == active_cfg.search_byte)
            begin
                search_on = 1'b0;
                hit_position = base + 33'(j);
                verdict.status = ST_FOUND;
                verdict.match_offset = hit_position[31:0];
                return verdict;
            end
        end
        bytes_left = bytes_left - take;
        if (bytes_left == 0)
        begin
            // The last byte of the range sat in this word, so the answer comes
            // now, even when the range stops exactly on a word boundary.
            search_on = 1'b0;
            verdict.status = ST_NOT_FOUND;
            return verdict;
        end
        next_position = base + 33'(take);
        return verdict;
    endfunction

    // -----------------------------------------------------------------------
    // Word driver
    // -----------------------------------------------------------------------

    // A beat is predicted at the edge where it is taken, which keeps the
    // prediction in step with the block whatever the idling pattern. A new
    // beat, or a gap, is chosen only when the channel is free, so valid and
    // the payload hold steady while the block is not ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted_verdicts.push_back(search_word(in_data));
                sent_words++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap_left > 0)
                begin
                    send_gap_left--;
                    in_valid <= 1'b0;
                end
                else if (words_to_send.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1)
                begin
                    // An idle burst starts here, this cycle included.
                    send_gap_left = $urandom_range(0, 15);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_data  <= words_to_send.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result monitor
    // -----------------------------------------------------------------------

    // Each result beat taken is held against the oldest prediction, field by
    // field. The ready side stalls in bursts of its own, independent of the
    // sender, so back-pressure lands on every stage of the pipeline.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                case (out_data.status)
                    ST_SEARCHING: seen_searching++;
                    ST_FOUND:     seen_found++;
                    ST_NOT_FOUND: seen_not_found++;
                    default:      seen_ignored++;
                endcase
                if (predicted_verdicts.size() == 0)
                begin
                    $error("Result beat with nothing predicted: status %0d, match_offset %0d",
                           out_data.status, out_data.match_offset);
                    fail_count++;
                end
                else
                begin
                    oldest_verdict = predicted_verdicts.pop_front();
                    if (out_data.status !== oldest_verdict.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               oldest_verdict.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.match_offset !== oldest_verdict.match_offset)
                    begin
                        $error("match_offset: expected %0d, actual %0d",
                               oldest_verdict.match_offset, out_data.match_offset);
                        fail_count++;
                    end
                end
            end
            if (recv_stall_left > 0)
            begin
                recv_stall_left--;
                out_ready <= 1'b0;
            end
            else if (recv_idle_odds != 0 && $urandom_range(1, recv_idle_odds) == 1)
            begin
                recv_stall_left = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog
    // -----------------------------------------------------------------------

    // Any beat on any of the three channels counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Hung for %0d cycles with %0d results outstanding",
                     quiet_cycles, predicted_verdicts.size());
            $display("word_parallel_byte_search verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------

    function automatic logic [63:0] with_byte(logic [63:0] word, int lane, logic [7:0] value);
        logic [63:0] patched;
        patched = word;
        patched[lane*8 +: 8] = value;
        return patched;
    endfunction

    task automatic queue_word(input logic [63:0] word, input logic first);
        in_beat_t beat;
        beat.data_word  = word;
        beat.first_word = first;
        words_to_send.push_back(beat);
        queued_words++;
    endtask

    // Waits until every queued word has gone in and every result has come out,
    // then lets the pipeline settle. Called on a clock edge.
    task automatic wait_for_drain();
        while (words_to_send.size() != 0 || in_valid || predicted_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write. Valid is left high so that back-to-back writes run
    // without a gap; the caller lowers it after the last one. The unused
    // upper bits of the data carry random junk, which the block must drop.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (index)
            REG_SEARCH_BYTE:  active_cfg.search_byte      = value[7:0];
            REG_START_OFFSET: active_cfg.start_offset     = value[START_W-1:0];
            REG_RANGE_LENGTH: active_cfg.range_length     = value[RANGE_W-1:0];
            default:          active_cfg.big_endian_lanes = value[0];
        endcase
    endtask

    task automatic apply_setting(input logic [7:0] search_byte, input logic [2:0] start,
                                 input logic [31:0] length, input logic big_endian);
        logic [31:0] junk;
        wait_for_drain();
        junk = $urandom;
        write_register(REG_SEARCH_BYTE, {junk[31:8], search_byte});
        write_register(REG_START_OFFSET, {junk[28:0], start});
        write_register(REG_RANGE_LENGTH, length);
        junk = $urandom;
        write_register(REG_BIG_ENDIAN, {junk[31:1], big_endian});
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    // Fills one random phase under the current setting. Most of it is whole
    // searches with random content: a first word and then as many words as the
    // range needs, up to MAX_SEQ_WORDS, sometimes with trailing words to be ignored. The
    // rest is stray words with no search running and searches cut short by a
    // fresh first word. The match density changes from search to search, and
    // half the searches get the wanted byte planted in a random lane.
    task automatic queue_random_phase(input int unsigned phase_words);
        int unsigned goal;
        int unsigned kind;
        longint      span_words;
        int unsigned seq_words;
        int unsigned extra_words;
        int unsigned density;
        bit          plant;
        int unsigned plant_word;
        int unsigned plant_lane;
        logic [63:0] word;
        logic [7:0]  lane_byte;
        goal = queued_words + phase_words;
        while (queued_words < goal)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // Stray words; ignored unless a search is still open.
                repeat ($urandom_range(1, 3))
                    queue_word({$urandom, $urandom}, 1'b0);
            end
            else
            begin
                span_words = (longint'(active_cfg.start_offset)
                              + longint'(active_cfg.range_length) + 7) / 8;
                if (span_words < 1)
                    span_words = 1;
                if (span_words > MAX_SEQ_WORDS)
                    span_words = MAX_SEQ_WORDS;
                seq_words = int'(span_words);
                if (kind == 1)
                    seq_words = $urandom_range(1, seq_words);
                extra_words = (kind == 2) ? $urandom_range(1, 2) : 0;
                density    = $urandom_range(4, 96);
                plant      = 1'($urandom_range(0, 1));
                plant_word = $urandom_range(0, seq_words - 1);
                plant_lane = $urandom_range(0, 7);
                for (int w = 0; w < int'(seq_words + extra_words); w++)
                begin
                    for (int lane = 0; lane < 8; lane++)
                    begin
                        lane_byte = ($urandom_range(1, density) == 1) ?
                                    active_cfg.search_byte : 8'($urandom);
                        if (plant && w == int'(plant_word) && lane == int'(plant_lane))
                            lane_byte = active_cfg.search_byte;
                        word[lane*8 +: 8] = lane_byte;
                    end
                    queue_word(word, w == 0);
                end
            end
        end
    endtask

    initial
    begin : stimulus
        logic [7:0]  pick_byte;
        logic [31:0] pick_length;
        active_cfg    = '0;
        bytes_left    = '0;
        next_position = '0;
        search_on     = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with light idling on both sides.
        send_idle_odds = 4;
        recv_idle_odds = 4;

        // Zero length answers not found on the first word; the next word has
        // no search to belong to.
        apply_setting(8'h00, 3'd0, 32'd0, 1'b0);
        queue_word(64'h0, 1'b1);
        queue_word(64'h0000_0000_0000_0000, 1'b0);

        // One byte at the very last address, which the big-endian order puts
        // in bits 7:0.
        apply_setting(8'hFF, 3'd7, 32'd1, 1'b1);
        queue_word(with_byte(64'h0, 0, 8'hFF), 1'b1);
        queue_word(64'hFFFF_FFFF_FFFF_FF00, 1'b1);

        // Range ending exactly on a word boundary: a match in a lane before
        // the start is masked, the answer comes at once, and a following word
        // is ignored. Then a hit in the top lane.
        apply_setting(8'hA5, 3'd3, 32'd5, 1'b0);
        queue_word(with_byte(64'h0, 2, 8'hA5), 1'b1);
        queue_word(64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
        queue_word(with_byte(64'h0, 7, 8'hA5), 1'b1);

        // Largest length: the search carries over two words, finds the byte at
        // address 7 of the third, ignores the next word, and then a fresh
        // first word cuts a new search short with a hit at address 0.
        apply_setting(8'h5A, 3'd0, 32'hFFFF_FFFF, 1'b1);
        queue_word(64'h0, 1'b1);
        queue_word(64'h0, 1'b0);
        queue_word(with_byte(64'h0, 0, 8'h5A), 1'b0);
        queue_word(64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
        queue_word(64'h0, 1'b1);
        queue_word(with_byte(64'h0, 7, 8'h5A), 1'b1);

        // Range spanning three words: a match before the start and one past
        // the end are both masked, then a hit in the second word of a new
        // search.
        apply_setting(8'h3C, 3'd5, 32'd12, 1'b0);
        queue_word(with_byte(64'h0, 4, 8'h3C), 1'b1);
        queue_word(64'h0, 1'b0);
        queue_word(with_byte(64'h0, 1, 8'h3C), 1'b0);
        queue_word(64'h0, 1'b1);
        queue_word(with_byte(64'h0, 0, 8'h3C), 1'b0);

        // Start in the last lane, match on the final byte of the range.
        apply_setting(8'h00, 3'd7, 32'd9, 1'b1);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        queue_word(with_byte(64'hFFFF_FFFF_FFFF_FFFF, 0, 8'h00), 1'b0);

        // One whole word: hit in the top lane, then not found with no need
        // for a further word.
        apply_setting(8'h81, 3'd0, 32'd8, 1'b0);
        queue_word(with_byte(64'h0, 7, 8'h81), 1'b1);
        queue_word(64'h0, 1'b1);

        // Random part: a fresh setting per phase, biased towards the extremes,
        // and a fresh idling pattern. The tail runs flat out.
        while (queued_words < WORD_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       pick_byte = 8'h00;
                1:       pick_byte = 8'hFF;
                default: pick_byte = 8'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       pick_length = 32'd0;
                1:       pick_length = 32'hFFFF_FFFF;
                2:       pick_length = $urandom;
                default: pick_length = $urandom_range(1, 48);
            endcase
            apply_setting(pick_byte, 3'($urandom_range(0, 7)), pick_length,
                          1'($urandom_range(0, 1)));
            if (queued_words + QUIET_TAIL >= WORD_TARGET)
            begin
                send_idle_odds = 0;
                recv_idle_odds = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       send_idle_odds = 0;
                    1:       send_idle_odds = 2;
                    2:       send_idle_odds = 6;
                    default: send_idle_odds = 16;
                endcase
                case ($urandom_range(0, 3))
                    0:       recv_idle_odds = 0;
                    1:       recv_idle_odds = 2;
                    2:       recv_idle_odds = 6;
                    default: recv_idle_odds = 16;
                endcase
            end
            queue_random_phase($urandom_range(60, 120));
        end

        // Let the last results come out, then keep the clock running so that any
        // stray beat would still show.
        wait_for_drain();
        repeat (8) @(posedge clk);

        $display("Sent %0d words under %0d register settings.", sent_words, setting_count);
        $display("Results seen: %0d found, %0d not found, %0d searching, %0d ignored.",
                 seen_found, seen_not_found, seen_searching, seen_ignored);
        if (fail_count == 0)
            $display("word_parallel_byte_search verification clean");
        else
            $display("word_parallel_byte_search verification failed");
        $finish;
    end

endmodule
